@@ src/sva_pkg.sv @@
`default_nettype none

package sva_pkg;

    // Event codes carried by the action field.
    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_FINISH   = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // Envelope stage of one voice.
    typedef enum logic [1:0] {
        STG_IDLE    = 2'd0,
        STG_ATTACK  = 2'd1,
        STG_RELEASE = 2'd2
    } stage_t;

    // How a voice was picked; a lower code has higher priority.
    typedef enum logic [1:0] {
        KIND_RETRIG  = 2'd0,
        KIND_IDLE    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_FORCED  = 2'd3
    } kind_t;

    // Field widths fixed by the event format.
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;

    // Command broadcast from the controller to every voice cell.
    typedef struct packed {
        logic               capture;
        logic [NOTE_W-1:0]  cap_note;
        logic               wr_en;
        action_t            op;
        logic [NOTE_W-1:0]  wr_note;
        logic [VEL_W-1:0]   wr_vel;
    } cell_cmd_t;

    // Read data passed along the row of cells.
    typedef struct packed {
        logic [VEL_W-1:0] vel;
        stage_t           stage;
    } voice_rd_t;

endpackage

`default_nettype wire

@@ src/sva_in_if.sv @@
`default_nettype none

interface sva_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [2:0] voice_index;

    modport source (output valid, output action, output note, output velocity,
                    output voice_index, input ready);
    modport sink   (input valid, input action, input note, input velocity,
                    input voice_index, output ready);

endinterface

`default_nettype wire

@@ src/sva_out_if.sv @@
`default_nettype none

interface sva_out_if;

    logic       valid;
    logic       ready;
    logic [2:0] chosen_voice;
    logic [1:0] pick_kind;
    logic       keep_phase;
    logic [6:0] stored_velocity;
    logic [1:0] stage_after;

    modport source (output valid, output chosen_voice, output pick_kind,
                    output keep_phase, output stored_velocity, output stage_after,
                    input ready);
    modport sink   (input valid, input chosen_voice, input pick_kind,
                    input keep_phase, input stored_velocity, input stage_after,
                    output ready);

endinterface

`default_nettype wire

@@ src/sva_voice_cell.sv @@
`default_nettype none

module sva_voice_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sva_pkg::cell_cmd_t  cmd,
    input  wire logic                wr_sel,
    input  wire logic                rd_sel,
    input  wire sva_pkg::kind_t      rank_in,
    input  wire logic [IDX_W-1:0]    pick_in,
    output sva_pkg::kind_t           rank_out,
    output logic [IDX_W-1:0]         pick_out,
    input  wire sva_pkg::voice_rd_t  rd_in,
    output sva_pkg::voice_rd_t       rd_out
);
    import sva_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              active_reg;
    stage_t            stage_reg;
    logic              match_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    kind_t             own_rank;
    logic              do_write;

    assign do_write = cmd.wr_en && wr_sel;

    // Control state of the voice, and the retrigger match taken when a word arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            stage_reg  <= STG_IDLE;
            match_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                match_reg <= active_reg && (note_reg == cmd.cap_note);
            end
            if (do_write)
            begin
                case (cmd.op)
                    ACT_NOTE_ON:
                    begin
                        stage_reg  <= STG_ATTACK;
                        active_reg <= 1'b1;
                    end
                    ACT_NOTE_OFF:
                    begin
                        if (stage_reg != STG_IDLE)
                        begin
                            stage_reg <= STG_RELEASE;
                        end
                    end
                    ACT_FINISH:
                    begin
                        stage_reg  <= STG_IDLE;
                        active_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Note and velocity are only meaningful once a note-on has written them.
    always_ff @(posedge clk)
    begin
        if (do_write && (cmd.op == ACT_NOTE_ON))
        begin
            note_reg <= cmd.wr_note;
            vel_reg  <= cmd.wr_vel;
        end
    end

    // This voice's own claim, from best to worst.
    always_comb
    begin
        if (match_reg)
        begin
            own_rank = KIND_RETRIG;
        end
        else if (!active_reg)
        begin
            own_rank = KIND_IDLE;
        end
        else if (stage_reg == STG_RELEASE)
        begin
            own_rank = KIND_RELEASE;
        end
        else
        begin
            own_rank = KIND_FORCED;
        end
    end

    // Take over the running best only when strictly better, so the lowest voice wins ties.
    always_comb
    begin
        if (own_rank < rank_in)
        begin
            rank_out = own_rank;
            pick_out = MY_IDX;
        end
        else
        begin
            rank_out = rank_in;
            pick_out = pick_in;
        end
    end

    // Read chain: the selected voice places its state on the row.
    assign rd_out = rd_sel ? voice_rd_t'{vel: vel_reg, stage: stage_reg} : rd_in;

endmodule

`default_nettype wire

@@ src/synth_voice_allocator_top.sv @@
`default_nettype none

// Polyphonic voice allocator. Each word on req is a note-on, a note-off or
// a voice-finished event; every word gives exactly one result word on rsp.
// The voices sit in a row of cells. When a word is taken, each cell
// compares its note with the incoming note; then, in the pick state, a
// priority chain runs through the row (retrigger, then lowest idle voice,
// then lowest releasing voice, else voice 0), and once the output register
// is free the chosen cell is updated and the result is loaded into it. An
// event passes through a compare step and a chain step; a new word is taken
// while an earlier result still waits, and the block holds in the pick
// state only while that result has not been taken.
module synth_voice_allocator_top #(
    parameter int NUM_VOICES = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sva_in_if.sink    req,
    sva_out_if.source rsp
);
    import sva_pkg::*;

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_PICK
    } state_t;

    state_t            state_reg;
    action_t           act_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic [2:0]        idx_reg;
    logic              out_valid_reg;
    logic [2:0]        chosen_reg;
    logic [1:0]        kind_reg;
    logic              keep_reg;
    logic [VEL_W-1:0]  svel_reg;
    logic [1:0]        stage_out_reg;

    logic              accept;
    logic              fire;
    logic [VEL_W-1:0]  vel_fix;
    cell_cmd_t         cmd;
    logic [NUM_VOICES-1:0] wr_sel;
    logic [NUM_VOICES-1:0] rd_sel;

    kind_t             rank_w [NUM_VOICES+1];
    logic [IDX_W-1:0]  pick_w [NUM_VOICES+1];
    voice_rd_t         rd_w   [NUM_VOICES+1];

    kind_t             kind_next;
    logic [2:0]        chosen_next;
    logic              keep_next;
    logic [VEL_W-1:0]  svel_next;
    stage_t            stage_next;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == ST_PICK) && (!out_valid_reg || rsp.ready);
    assign vel_fix   = (vel_reg == '0) ? VEL_W'(1) : vel_reg;

    // Command to the cells: match capture on arrival, update on the pick cycle.
    always_comb
    begin
        cmd.capture  = accept;
        cmd.cap_note = req.note;
        cmd.wr_en    = fire;
        cmd.op       = act_reg;
        cmd.wr_note  = note_reg;
        cmd.wr_vel   = vel_fix;
    end

    // Ends of the priority and read chains.
    assign rank_w[0] = KIND_FORCED;
    assign pick_w[0] = '0;
    assign rd_w[0]   = '{vel: '0, stage: STG_IDLE};

    // Row of voice cells with their select decoders.
    for (genvar i = 0; i < NUM_VOICES; i++)
    begin : g_cell
        assign rd_sel[i] = (int'(idx_reg) == i);
        assign wr_sel[i] = (act_reg == ACT_NOTE_ON) ?
                           (int'(pick_w[NUM_VOICES]) == i) : rd_sel[i];

        sva_voice_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .wr_sel   (wr_sel[i]),
            .rd_sel   (rd_sel[i]),
            .rank_in  (rank_w[i]),
            .pick_in  (pick_w[i]),
            .rank_out (rank_w[i+1]),
            .pick_out (pick_w[i+1]),
            .rd_in    (rd_w[i]),
            .rd_out   (rd_w[i+1])
        );
    end

    // Result word for the event under way.
    always_comb
    begin
        kind_next   = KIND_RETRIG;
        chosen_next = idx_reg;
        keep_next   = 1'b0;
        svel_next   = rd_w[NUM_VOICES].vel;
        stage_next  = rd_w[NUM_VOICES].stage;
        case (act_reg)
            ACT_NOTE_ON:
            begin
                kind_next   = rank_w[NUM_VOICES];
                chosen_next = 3'(pick_w[NUM_VOICES]);
                keep_next   = (rank_w[NUM_VOICES] == KIND_RETRIG);
                svel_next   = vel_fix;
                stage_next  = STG_ATTACK;
            end
            ACT_NOTE_OFF:
            begin
                if (rd_w[NUM_VOICES].stage != STG_IDLE)
                begin
                    stage_next = STG_RELEASE;
                end
            end
            ACT_FINISH:
            begin
                stage_next = STG_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, captured event and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_NOTE_ON;
            note_reg      <= '0;
            vel_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            chosen_reg    <= '0;
            kind_reg      <= '0;
            keep_reg      <= 1'b0;
            svel_reg      <= '0;
            stage_out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg   <= action_t'(req.action);
                        note_reg  <= req.note;
                        vel_reg   <= req.velocity;
                        idx_reg   <= req.voice_index;
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        chosen_reg    <= chosen_next;
                        kind_reg      <= kind_next;
                        keep_reg      <= keep_next;
                        svel_reg      <= svel_next;
                        stage_out_reg <= stage_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.chosen_voice    = chosen_reg;
    assign rsp.pick_kind       = kind_reg;
    assign rsp.keep_phase      = keep_reg;
    assign rsp.stored_velocity = svel_reg;
    assign rsp.stage_after     = stage_out_reg;

endmodule

`default_nettype wire

@@ bench/synth_voice_allocator_top_test.sv @@
`default_nettype none

module synth_voice_allocator_top_test;

    import sva_pkg::*;

    localparam int VOICES     = 8;
    localparam int DIR_ROWS   = 23;
    localparam int RAND_ITEMS = 450;
    localparam int TOTAL      = DIR_ROWS + RAND_ITEMS;
    localparam int CYCLE_CAP  = 100000;
    localparam int DRAIN      = 20;

    // One event word as it goes into the allocator.
    typedef struct packed {
        action_t    act;
        logic [6:0] note;
        logic [6:0] vel;
        logic [2:0] idx;
    } note_event_t;

    // One result word as it comes out of the allocator.
    typedef struct packed {
        logic [2:0] voice;
        kind_t      kind;
        logic       keep;
        logic [6:0] vel;
        stage_t     stage;
    } voice_pick_t;

    // A directed row; typed rows carry their own expected result.
    typedef struct packed {
        note_event_t ev;
        logic        typed;
        voice_pick_t want;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // Empty pool: first idle voice, velocity zero stored as one.
        '{'{ACT_NOTE_ON,  7'd0,   7'd0,   3'd0}, 1'b1,
          '{3'd0, KIND_IDLE,    1'b0, 7'd1,   STG_ATTACK}},
        '{'{ACT_NOTE_ON,  7'd127, 7'd127, 3'd7}, 1'b1,
          '{3'd1, KIND_IDLE,    1'b0, 7'd127, STG_ATTACK}},
        // Same note again keeps the phase.
        '{'{ACT_NOTE_ON,  7'd0,   7'd5,   3'd0}, 1'b1,
          '{3'd0, KIND_RETRIG,  1'b1, 7'd5,   STG_ATTACK}},
        // Fill the rest of the pool.
        '{'{ACT_NOTE_ON,  7'd10,  7'd1,   3'd0}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd11,  7'd2,   3'd7}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd12,  7'd64,  3'd0}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd13,  7'd100, 3'd7}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd14,  7'd126, 3'd0}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd15,  7'd0,   3'd0}, 1'b0, '0},
        // Every voice busy and none releasing: voice 0 is stolen.
        '{'{ACT_NOTE_ON,  7'd20,  7'd33,  3'd0}, 1'b1,
          '{3'd0, KIND_FORCED,  1'b0, 7'd33,  STG_ATTACK}},
        '{'{ACT_NOTE_OFF, 7'd0,   7'd0,   3'd3}, 1'b0, '0},
        '{'{ACT_NOTE_OFF, 7'd0,   7'd0,   3'd5}, 1'b0, '0},
        // Lowest releasing voice is stolen.
        '{'{ACT_NOTE_ON,  7'd30,  7'd40,  3'd0}, 1'b1,
          '{3'd3, KIND_RELEASE, 1'b0, 7'd40,  STG_ATTACK}},
        // Retrigger of a voice that is in release.
        '{'{ACT_NOTE_ON,  7'd13,  7'd50,  3'd0}, 1'b0, '0},
        '{'{ACT_FINISH,   7'd0,   7'd0,   3'd2}, 1'b0, '0},
        // Finish and note-off on a voice that is already idle.
        '{'{ACT_FINISH,   7'd0,   7'd0,   3'd2}, 1'b0, '0},
        '{'{ACT_NOTE_OFF, 7'd0,   7'd0,   3'd2}, 1'b0, '0},
        // Unused action code only reports the voice.
        '{'{ACT_NONE,     7'd127, 7'd127, 3'd7}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd99,  7'd77,  3'd0}, 1'b0, '0},
        // A finished voice keeps a stale note that must not retrigger.
        '{'{ACT_FINISH,   7'd0,   7'd0,   3'd6}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd14,  7'd127, 3'd0}, 1'b0, '0},
        '{'{ACT_NOTE_ON,  7'd14,  7'd9,   3'd0}, 1'b0, '0},
        '{'{ACT_NONE,     7'd0,   7'd0,   3'd0}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    sva_in_if  req ();
    sva_out_if rsp ();

    synth_voice_allocator_top #(.NUM_VOICES(VOICES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the voice pool.
    logic       slot_live  [VOICES];
    logic [6:0] slot_note  [VOICES];
    logic [6:0] slot_vel   [VOICES];
    stage_t     slot_stage [VOICES];
    bit         slot_used  [VOICES];

    voice_pick_t pending_picks [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    bit          calm;

    // Applies one event to the shadow pool and returns the result word it gives.
    function automatic voice_pick_t allocate_voice(input note_event_t ev);
        voice_pick_t res;
        int          pick;
        kind_t       how;
        bit          found;
        res.voice = ev.idx;
        res.kind  = KIND_RETRIG;
        res.keep  = 1'b0;
        res.vel   = '0;
        res.stage = STG_IDLE;
        if (ev.act == ACT_NOTE_ON)
        begin
            found = 1'b0;
            pick  = 0;
            how   = KIND_FORCED;
            for (int i = 0; i < VOICES; i++)
                if (!found && slot_live[i] && slot_note[i] == ev.note)
                begin
                    found = 1'b1;
                    pick  = i;
                    how   = KIND_RETRIG;
                end
            for (int i = 0; i < VOICES; i++)
                if (!found && !slot_live[i])
                begin
                    found = 1'b1;
                    pick  = i;
                    how   = KIND_IDLE;
                end
            for (int i = 0; i < VOICES; i++)
                if (!found && slot_stage[i] == STG_RELEASE)
                begin
                    found = 1'b1;
                    pick  = i;
                    how   = KIND_RELEASE;
                end
            res.keep         = slot_live[pick] && slot_note[pick] == ev.note;
            slot_note[pick]  = ev.note;
            slot_vel[pick]   = (ev.vel == 0) ? 7'd1 : ev.vel;
            slot_stage[pick] = STG_ATTACK;
            slot_live[pick]  = 1'b1;
            slot_used[pick]  = 1'b1;
            res.voice = pick[2:0];
            res.kind  = how;
            res.vel   = slot_vel[pick];
            res.stage = slot_stage[pick];
        end
        else
        begin
            if (ev.act == ACT_NOTE_OFF)
            begin
                if (slot_stage[ev.idx] != STG_IDLE)
                    slot_stage[ev.idx] = STG_RELEASE;
            end
            else if (ev.act == ACT_FINISH)
            begin
                slot_stage[ev.idx] = STG_IDLE;
                slot_live[ev.idx]  = 1'b0;
            end
            res.vel   = slot_vel[ev.idx];
            res.stage = slot_stage[ev.idx];
        end
        return res;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_CAP)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: ready drops in random bursts except in calm stretches.
    initial
    begin : rsp_stall
        int unsigned hold;
        logic        rdy;
        hold = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                hold = 0;
                rdy  = 1'b1;
            end
            else if (hold != 0)
            begin
                hold--;
                rdy = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 10) - 1;
                rdy  = 1'b0;
            end
            else
                rdy = 1'b1;
            rsp.ready <= rdy;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        voice_pick_t got;
        voice_pick_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.voice = rsp.chosen_voice;
            got.kind  = kind_t'(rsp.pick_kind);
            got.keep  = rsp.keep_phase;
            got.vel   = rsp.stored_velocity;
            got.stage = stage_t'(rsp.stage_after);
            if (pending_picks.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"unexpected result word: ",
                              "voice %0d kind %0d keep %0d vel %0d stage %0d"},
                             got.voice, got.kind, got.keep, got.vel, got.stage);
            end
            else
            begin
                want = pending_picks.pop_front();
                if (got.voice !== want.voice || got.kind !== want.kind ||
                    got.keep !== want.keep || got.vel !== want.vel ||
                    got.stage !== want.stage)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch at cycle %0d: ",
                                  "want voice %0d kind %0d keep %0d vel %0d stage %0d, ",
                                  "got voice %0d kind %0d keep %0d vel %0d stage %0d"},
                                 cycle_cnt, want.voice, want.kind, want.keep, want.vel,
                                 want.stage, got.voice, got.kind, got.keep, got.vel,
                                 got.stage);
                end
            end
        end
    end

    // Reset, then the directed table followed by random event words.
    initial
    begin : drive
        note_event_t ev;
        voice_pick_t pred;
        logic        typed;
        voice_pick_t want;
        int          r;
        int          v;
        mismatch_cnt = 0;
        calm         = 1'b0;
        for (int i = 0; i < VOICES; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_note[i]  = '0;
            slot_vel[i]   = '0;
            slot_stage[i] = STG_IDLE;
            slot_used[i]  = 1'b0;
        end
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.action      <= ACT_NOTE_ON;
        req.note        <= '0;
        req.velocity    <= '0;
        req.voice_index <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < TOTAL; k++)
        begin
            if (k < DIR_ROWS)
            begin
                ev    = DIR_TABLE[k].ev;
                typed = DIR_TABLE[k].typed;
                want  = DIR_TABLE[k].want;
            end
            else
            begin
                typed = 1'b0;
                want  = '0;
                // Mostly note-ons and note-offs, so the pool fills and voices get stolen.
                r = $urandom_range(0, 19);
                if (r < 10)
                    ev.act = ACT_NOTE_ON;
                else if (r < 15)
                    ev.act = ACT_NOTE_OFF;
                else if (r < 19)
                    ev.act = ACT_FINISH;
                else
                    ev.act = ACT_NONE;
                // Reuse held notes often enough to hit retriggers.
                r = $urandom_range(0, 9);
                v = $urandom_range(0, VOICES - 1);
                if (r < 4 && slot_used[v])
                    ev.note = slot_note[v];
                else if (r < 7)
                    ev.note = 7'(60 + $urandom_range(0, 7));
                else
                    ev.note = 7'($urandom_range(0, 127));
                ev.vel = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
                // Only voices that have held a note may be addressed.
                do
                    ev.idx = 3'($urandom_range(0, VOICES - 1));
                while (!slot_used[ev.idx]);
            end

            calm = (k >= 200 && k < 260) || (k >= TOTAL - 60);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            req.valid       <= 1'b1;
            req.action      <= ev.act;
            req.note        <= ev.note;
            req.velocity    <= ev.vel;
            req.voice_index <= ev.idx;
            do
                @(posedge clk);
            while (!req.ready);

            pred = allocate_voice(ev);
            pending_picks.push_back(typed ? want : pred);
        end
        req.valid <= 1'b0;

        // Drain the outstanding results, then let the bench idle before the final check.
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (pending_picks.size() != 0)
            $display("%0d result words never arrived", pending_picks.size());
        if (mismatch_cnt == 0 && pending_picks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
